// File: hdl/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// Shared types and constants of the escape-time pixel evaluator.
// ----------------------------------------------------------------------------
package met_pkg;

    // input item: one pixel coordinate
    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [7:0]  brightness;
        logic [11:0] last_index;
        logic        in_set;
    } out_item_t;

    // configuration register indexes
    localparam logic [7:0] REG_ORIGIN_RE       = 8'd0;
    localparam logic [7:0] REG_ORIGIN_IM       = 8'd1;
    localparam logic [7:0] REG_PIXEL_STEP      = 8'd2;
    localparam logic [7:0] REG_ITERATION_LIMIT = 8'd3;

    // configuration reset values
    localparam logic [31:0] ORIGIN_RE_RST       = 32'hF400_0000;
    localparam logic [31:0] ORIGIN_IM_RST       = 32'hF400_0000;
    localparam logic [30:0] PIXEL_STEP_RST      = 31'd559240;
    localparam logic [12:0] ITERATION_LIMIT_RST = 13'd150;

    // brightness scale and quotient width
    localparam int QUOT_BITS = 8;

    // iteration sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP,
        ST_SQUARE,
        ST_UPDATE
    } met_state_t;

endpackage

// File: hdl/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time evaluator for one pixel with a chained brightness divider.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | met_pkg::in_item_t
//  out     | output    | out_valid/out_stall | met_pkg::out_item_t
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One item at a time: a mapping state, up to limit+1 passes through the SQUARE
// and UPDATE states of the multiplier loop (the first pass only forms z1), 8
// divider cells and the output register; in_stall drops as the result enters
// that register, so no new item is taken before the last one leaves the chain.
// Reset clears control and loads the register defaults; no memory to clear.
// A stalled output holds the divider chain; in_stall stays high while busy.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
    parameter int MAX_ITER_LIMIT = 4096,
    parameter int FRAC_BITS      = 26
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  met_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output met_pkg::out_item_t  out_item,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int LW    = $clog2(MAX_ITER_LIMIT + 1);
    localparam int RW    = LW + met_pkg::QUOT_BITS;
    localparam int NCELL = met_pkg::QUOT_BITS;

    logic signed [31:0] origin_re_reg, origin_im_reg;
    logic [30:0]        pixel_step_reg;
    logic [12:0]        iteration_limit_reg;
    logic [LW-1:0]      lim_eff;

    logic               core_busy, core_done, core_inset;
    logic [LW-1:0]      core_last;
    logic               adv;

    logic [NCELL:0]     c_v;
    logic [RW-1:0]      c_rem   [NCELL+1];
    logic [LW-1:0]      c_lim   [NCELL+1];
    logic [7:0]         c_q     [NCELL+1];
    logic [11:0]        c_last  [NCELL+1];
    logic [NCELL:0]     c_inset;

    logic               out_valid_reg;
    met_pkg::out_item_t out_item_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_reg       <= met_pkg::ORIGIN_RE_RST;
            origin_im_reg       <= met_pkg::ORIGIN_IM_RST;
            pixel_step_reg      <= met_pkg::PIXEL_STEP_RST;
            iteration_limit_reg <= met_pkg::ITERATION_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                met_pkg::REG_ORIGIN_RE:       origin_re_reg       <= cfg_data;
                met_pkg::REG_ORIGIN_IM:       origin_im_reg       <= cfg_data;
                met_pkg::REG_PIXEL_STEP:      pixel_step_reg      <= cfg_data[30:0];
                met_pkg::REG_ITERATION_LIMIT: iteration_limit_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // clamp the limit into 1..MAX_ITER_LIMIT
    always_comb
    begin
        if (iteration_limit_reg == 13'd0)
            lim_eff = LW'(1);
        else if (32'(iteration_limit_reg) > 32'(MAX_ITER_LIMIT))
            lim_eff = LW'(MAX_ITER_LIMIT);
        else
            lim_eff = LW'(iteration_limit_reg);
    end

    assign in_stall = core_busy || (c_v != '0);

    met_iter #(
        .LW        (LW),
        .FRAC_BITS (FRAC_BITS)
    ) u_iter (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_valid && !in_stall),
        .pixel_x    (in_item.pixel_x),
        .pixel_y    (in_item.pixel_y),
        .origin_re  (origin_re_reg),
        .origin_im  (origin_im_reg),
        .pixel_step (pixel_step_reg),
        .limit      (lim_eff),
        .busy       (core_busy),
        .done       (core_done),
        .res_last   (core_last),
        .res_inset  (core_inset)
    );

    // chain head: dividend last*255
    assign c_v[0]     = core_done;
    assign c_rem[0]   = (RW'(core_last) << 8) - RW'(core_last);
    assign c_lim[0]   = lim_eff;
    assign c_q[0]     = 8'd0;
    assign c_last[0]  = 12'(core_last);
    assign c_inset[0] = core_inset;

    assign adv = !(c_v[NCELL] && out_valid_reg && out_stall);

    // divider cells, most significant quotient bit first
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        met_div_cell #(
            .RW    (RW),
            .LW    (LW),
            .SHIFT (NCELL - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_v      (c_v[i]),
            .in_rem    (c_rem[i]),
            .in_lim    (c_lim[i]),
            .in_q      (c_q[i]),
            .in_last   (c_last[i]),
            .in_inset  (c_inset[i]),
            .out_v     (c_v[i+1]),
            .out_rem   (c_rem[i+1]),
            .out_lim   (c_lim[i+1]),
            .out_q     (c_q[i+1]),
            .out_last  (c_last[i+1]),
            .out_inset (c_inset[i+1])
        );
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (c_v[NCELL] && adv)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (c_v[NCELL] && adv)
        begin
            out_item_reg.brightness <= c_inset[NCELL] ? 8'd0 : c_q[NCELL];
            out_item_reg.last_index <= c_last[NCELL];
            out_item_reg.in_set     <= c_inset[NCELL];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted item did not raise in_stall");

    a_one_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(c_v))
        else $error("more than one item in divider chain");

    a_done_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        core_done |-> (c_v[NCELL:1] == '0))
        else $error("core finished while divider chain busy");

    a_inset_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.in_set |-> out_item.brightness == 8'd0)
        else $error("in-set result with nonzero brightness");

endmodule

// File: hdl/met_div_cell.sv
// ----------------------------------------------------------------------------
// met_div_cell
// One cell of the brightness divider chain: settles one quotient bit.
// ----------------------------------------------------------------------------
module met_div_cell #(
    parameter int RW    = 21,
    parameter int LW    = 13,
    parameter int SHIFT = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_v,
    input  logic [RW-1:0] in_rem,
    input  logic [LW-1:0] in_lim,
    input  logic [7:0]    in_q,
    input  logic [11:0]   in_last,
    input  logic          in_inset,
    output logic          out_v,
    output logic [RW-1:0] out_rem,
    output logic [LW-1:0] out_lim,
    output logic [7:0]    out_q,
    output logic [11:0]   out_last,
    output logic          out_inset
);

    logic          v_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic [LW-1:0] lim_reg;
    logic [7:0]    q_reg, q_next;
    logic [11:0]  last_reg;
    logic          inset_reg;
    logic [RW-1:0] divisor;
    logic          fits;

    // restoring step against the shifted limit
    always_comb
    begin
        divisor  = RW'(in_lim) << SHIFT;
        fits     = (in_rem >= divisor);
        rem_next = fits ? (in_rem - divisor) : in_rem;
        q_next   = in_q | (fits ? (8'd1 << SHIFT) : 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg   <= rem_next;
            lim_reg   <= in_lim;
            q_reg     <= q_next;
            last_reg  <= in_last;
            inset_reg <= in_inset;
        end
    end

    assign out_v     = v_reg;
    assign out_rem   = rem_reg;
    assign out_lim   = lim_reg;
    assign out_q     = q_reg;
    assign out_last  = last_reg;
    assign out_inset = inset_reg;

endmodule

// File: hdl/met_iter.sv
// ----------------------------------------------------------------------------
// met_iter
// Pixel mapping and the z = z*z + c iteration loop through the SQUARE and UPDATE states.
// ----------------------------------------------------------------------------
module met_iter #(
    parameter int LW        = 13,
    parameter int FRAC_BITS = 26
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [11:0]        pixel_x,
    input  logic [11:0]        pixel_y,
    input  logic signed [31:0] origin_re,
    input  logic signed [31:0] origin_im,
    input  logic [30:0]        pixel_step,
    input  logic [LW-1:0]      limit,
    output logic               busy,
    output logic               done,
    output logic [LW-1:0]      res_last,
    output logic               res_inset
);

    localparam int TH = 2 * FRAC_BITS + 4;

    met_pkg::met_state_t state_reg, state_next;

    logic [42:0]        prx_reg, pry_reg;
    logic signed [31:0] cr_reg, ci_reg, a_reg, b_reg;
    logic signed [63:0] aa_reg, bb_reg, ab_reg;
    logic [LW-1:0]      k_reg, last_reg, lim_reg;

    logic signed [65:0] map_re, map_im, re2, im2, sh_re, sh_im;
    logic signed [31:0] cr_next, ci_next, a_next, b_next;
    logic [65:0]        mag;
    logic               esc, at_limit, first;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -66'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // datapath: mapping sum, update and escape test
    always_comb
    begin
        map_re  = 66'(origin_re) + $signed({23'b0, prx_reg});
        map_im  = 66'(origin_im) + $signed({23'b0, pry_reg});
        cr_next = sat32(map_re);
        ci_next = sat32(map_im);
        re2     = 66'(aa_reg) - 66'(bb_reg);
        if (ab_reg >= 64'sh4000_0000_0000_0000)
            im2 = 66'sh0_7FFF_FFFF_FFFF_FFFF;
        else
            im2 = 66'(ab_reg) <<< 1;
        sh_re   = re2 >>> FRAC_BITS;
        sh_im   = im2 >>> FRAC_BITS;
        a_next  = sat32(sh_re + 66'(cr_reg));
        b_next  = sat32(sh_im + 66'(ci_reg));
        mag     = 66'($unsigned(aa_reg)) + 66'($unsigned(bb_reg));
        esc     = (TH >= 66) ? 1'b0 : (mag > (66'd1 << TH));
        first   = (k_reg == '0);
        at_limit = (k_reg == lim_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            met_pkg::ST_IDLE:   if (start) state_next = met_pkg::ST_MAP;
            met_pkg::ST_MAP:    state_next = met_pkg::ST_SQUARE;
            met_pkg::ST_SQUARE: state_next = met_pkg::ST_UPDATE;
            met_pkg::ST_UPDATE:
                if (!first && (esc || at_limit))
                    state_next = met_pkg::ST_IDLE;
                else
                    state_next = met_pkg::ST_SQUARE;
            default:            state_next = met_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy      = (state_reg != met_pkg::ST_IDLE);
        done      = 1'b0;
        res_inset = 1'b0;
        res_last  = last_reg;
        case (state_reg)
            met_pkg::ST_UPDATE:
            begin
                done      = !first && (esc || at_limit);
                res_inset = !esc;
                res_last  = esc ? last_reg : (k_reg - LW'(1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= met_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            met_pkg::ST_IDLE:
            begin
                prx_reg <= 43'(pixel_x) * 43'(pixel_step);
                pry_reg <= 43'(pixel_y) * 43'(pixel_step);
                lim_reg <= limit;
            end
            met_pkg::ST_MAP:
            begin
                cr_reg   <= cr_next;
                ci_reg   <= ci_next;
                a_reg    <= cr_next;
                b_reg    <= ci_next;
                k_reg    <= '0;
                last_reg <= '0;
            end
            met_pkg::ST_SQUARE:
            begin
                aa_reg <= a_reg * a_reg;
                bb_reg <= b_reg * b_reg;
                ab_reg <= a_reg * b_reg;
            end
            met_pkg::ST_UPDATE:
            begin
                if (!first && !esc)
                    last_reg <= k_reg - LW'(1);
                a_reg <= a_next;
                b_reg <= b_next;
                k_reg <= k_reg + LW'(1);
            end
            default: ;
        endcase
    end

endmodule
